// ===== hw/rtl/text_console_writer_top_assert.svh =====
// Assertion macros for the text console writer checker.
// Expects signals clk and arst_n in the scope where the macros are used.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while in reset
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while in reset
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_ctrl and text_console_writer_top.
package tcw_pkg;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_ERASE = 2'd1,
		OP_CLEAR = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_COPY,
		ST_FILL,
		ST_PUT,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [6:0] cursor_col;
		logic [4:0] cursor_row;
		logic       scrolled;
	} res_t;

	localparam logic [7:0] CH_NL         = 8'd10;
	localparam logic [7:0] CH_CR         = 8'd13;
	localparam logic [7:0] CH_SPACE      = 8'd32;
	localparam logic [7:0] ATTR_FALLBACK = 8'd7;

	localparam int NUM_COLORS = 3;

	localparam logic [1:0] REG_TOP_ROW = 2'd0;
	localparam logic [1:0] REG_COLOR0  = 2'd1;
	localparam logic [1:0] REG_COLOR1  = 2'd2;
	localparam logic [1:0] REG_COLOR2  = 2'd3;

	localparam logic [4:0] TOP_ROW_RESET = 5'd0;
	localparam logic [7:0] COLOR0_RESET  = 8'd5;
	localparam logic [7:0] COLOR1_RESET  = 8'd2;
	localparam logic [7:0] COLOR2_RESET  = 8'd3;

endpackage

// ===== hw/rtl/text_console_writer_top.sv =====
// Text console writer top: configuration registers, result register and
// the sequencer/store pair. Depends on tcw_pkg, tcw_ctrl, tcw_screen_mem.
//
// Usage: requests (op, terminal, char_code, cell_row, cell_col) enter on the
// in_valid/in_stall channel; each gives exactly one result (cell_char,
// cell_attr, cursor_col, cursor_row, scrolled) on out_valid/out_stall.
// Configuration (top_row, three colour bytes) is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
// Puts, erases, reads and newlines that stay on screen finish in the
// execute state and their result goes to the output register unless it
// is stalled; a new request is taken only once the last one is done.
// The screen store has one port per direction: one cell read and one
// written per cycle. A scroll or a clear walks rows top_row to the bottom
// row of the terminal's screen, one cell per cycle.
// After reset all TERMINALS * ROWS * COLS cells of the store (6000 at the
// defaults) are swept to spaces with in_stall high; cfg writes are taken then.
// A stalled result sits in the output register; one further result may be
// held inside while a new request waits behind in_stall.
module text_console_writer_top
	import tcw_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int TERMINALS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] op,
	input  logic [1:0] terminal,
	input  logic [7:0] char_code,
	input  logic [4:0] cell_row,
	input  logic [6:0] cell_col,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] cell_char,
	output logic [7:0] cell_attr,
	output logic [6:0] cursor_col,
	output logic [4:0] cursor_row,
	output logic       scrolled
);

	localparam int DEPTH = TERMINALS * ROWS * COLS;
	localparam int AW = $clog2(DEPTH);

	logic [4:0]                 top_row_q;
	logic [NUM_COLORS-1:0][7:0] color_q;
	logic                       out_valid_q;
	res_t                       out_q;
	res_t                       res;
	logic                       res_valid;
	logic                       out_free;
	logic                       mem_we;
	logic [AW-1:0]              mem_waddr;
	logic [AW-1:0]              mem_raddr;
	logic [7:0]                 mem_wdata;
	logic [7:0]                 mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_row_q  <= TOP_ROW_RESET;
			color_q[0] <= COLOR0_RESET;
			color_q[1] <= COLOR1_RESET;
			color_q[2] <= COLOR2_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOP_ROW: top_row_q  <= cfg_data[4:0];
				REG_COLOR0:  color_q[0] <= cfg_data;
				REG_COLOR1:  color_q[1] <= cfg_data;
				REG_COLOR2:  color_q[2] <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_char  = out_q.cell_char;
	assign cell_attr  = out_q.cell_attr;
	assign cursor_col = out_q.cursor_col;
	assign cursor_row = out_q.cursor_row;
	assign scrolled   = out_q.scrolled;

	tcw_ctrl #(
		.COLS(COLS),
		.ROWS(ROWS),
		.TERMINALS(TERMINALS),
		.AW(AW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.terminal(terminal),
		.char_code(char_code),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.top_row(top_row_q),
		.colors(color_q),
		.out_free(out_free),
		.res_valid(res_valid),
		.res(res),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	tcw_screen_mem #(
		.DEPTH(DEPTH),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

// ===== hw/rtl/tcw_screen_mem.sv =====
// Character store for all terminal screens: one write and one read port,
// registered read data. No dependencies.
module tcw_screen_mem #(
	parameter int DEPTH = 6000,
	parameter int AW = 13
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] store_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Request sequencer: cursors, scroll/clear sweeps and read-modify-write
// of the screen store. Depends on tcw_pkg.
module tcw_ctrl
	import tcw_pkg::*;
#(
	parameter int COLS = 80,
	parameter int ROWS = 25,
	parameter int TERMINALS = 3,
	parameter int AW = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [1:0]                 terminal,
	input  logic [7:0]                 char_code,
	input  logic [4:0]                 cell_row,
	input  logic [6:0]                 cell_col,
	input  logic [4:0]                 top_row,
	input  logic [NUM_COLORS-1:0][7:0] colors,
	input  logic                       out_free,
	output logic                       res_valid,
	output res_t                       res,
	output logic                       mem_we,
	output logic [AW-1:0]              mem_waddr,
	output logic [7:0]                 mem_wdata,
	output logic [AW-1:0]              mem_raddr,
	input  logic [7:0]                 mem_rdata
);

	localparam int CW = $clog2(COLS + 1);
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;
	localparam int DEPTH = TERMINALS * ROWS * COLS;
	localparam logic [AW-1:0] ROWS_A = AW'(ROWS);
	localparam logic [AW-1:0] COLS_A = AW'(COLS);
	localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);
	localparam logic [RW-1:0] BOTTOM = RW'(ROWS - 1);
	localparam logic [CW-1:0] WRAP_COL = CW'(COLS);

	function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] t,
			input logic [AW-1:0] r, input logic [AW-1:0] c);
		return (t * ROWS_A + r) * COLS_A + c;
	endfunction

	state_t state_q, state_d;
	op_t        op_q;
	logic [1:0] term_q;
	logic       term_ok_q;
	logic       rd_ok_q;
	logic [7:0] char_q;
	logic [AW-1:0] ptr_q;
	logic [AW-1:0] last_q;
	logic       fill_put_q;
	logic       scrolled_q;
	res_t       res_q;
	res_t       res_d;
	logic [CW-1:0] col_q [TERMINALS];
	logic [RW-1:0] row_q [TERMINALS];

	logic [TW-1:0] tix;
	logic [CW-1:0] cur_col, nxt_col, wr_col;
	logic [RW-1:0] cur_row, nxt_row, wr_row, eff_top;
	logic [7:0]    top_ext, attr;
	logic          cur_we, bottom, wrap, nl, fin, accept, scroll_go;
	logic          wr_cursor;
	logic [AW-1:0] start_addr, end_addr;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	assign tix     = term_q[TW-1:0];
	assign cur_col = col_q[tix];
	assign cur_row = row_q[tix];
	assign bottom  = (cur_row == BOTTOM);
	assign wrap    = (cur_col >= WRAP_COL);
	assign nl      = (char_q == CH_NL) || (char_q == CH_CR);

	// top_row beyond the screen acts as the bottom row
	assign top_ext = {3'b000, top_row};
	assign eff_top = (top_ext >= 8'(ROWS)) ? BOTTOM : top_ext[RW-1:0];

	assign attr = (term_q == 2'd3) ? ATTR_FALLBACK : colors[term_q];

	assign start_addr = cell_addr(AW'(tix), AW'(eff_top), '0);
	assign end_addr   = cell_addr(AW'(tix), AW'(BOTTOM), AW'(COLS - 1));

	assign scroll_go = (state_q == ST_EXEC) && term_ok_q && (op_q == OP_PUT)
		&& (nl || wrap) && bottom;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (ptr_q == LAST_A) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (fin) begin
					state_d = out_free ? ST_IDLE : ST_HOLD;
				end else if (op_q == OP_CLEAR || eff_top == BOTTOM) begin
					state_d = ST_FILL;
				end else begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (ptr_q == last_q - COLS_A) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (ptr_q == last_q) begin
					if (fill_put_q) state_d = ST_PUT;
					else state_d = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_PUT: begin
				state_d = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_INIT;
		endcase
	end

	// outputs, memory port and cursor update
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = char_q;
		wr_cursor = 1'b0;
		wr_row    = cur_row;
		wr_col    = cur_col;
		cur_we    = 1'b0;
		nxt_col   = cur_col;
		nxt_row   = cur_row;
		fin       = 1'b0;
		mem_raddr = ptr_q;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = CH_SPACE;
			end
			ST_IDLE: begin
				mem_raddr = cell_addr(AW'(terminal), AW'(cell_row), AW'(cell_col));
			end
			ST_EXEC: begin
				mem_raddr = start_addr + COLS_A;
				if (!term_ok_q) begin
					fin = 1'b1;
				end else begin
					case (op_q)
						OP_READ: begin
							fin = 1'b1;
						end
						OP_CLEAR: begin
							cur_we  = 1'b1;
							nxt_col = '0;
							nxt_row = eff_top;
						end
						OP_ERASE: begin
							fin = 1'b1;
							if (!(wrap && bottom)) begin
								mem_we    = 1'b1;
								wr_cursor = 1'b1;
								mem_wdata = CH_SPACE;
								if (wrap) begin
									wr_row  = cur_row + 1'b1;
									wr_col  = '0;
									cur_we  = 1'b1;
									nxt_row = cur_row + 1'b1;
									nxt_col = '0;
								end
							end
						end
						default: begin
							if ((nl || wrap) && bottom) begin
								// scroll first; a printable character goes in afterwards, a newline is not stored
								cur_we  = 1'b1;
								nxt_col = '0;
							end else if (nl || wrap) begin
								fin     = 1'b1;
								cur_we  = 1'b1;
								nxt_row = cur_row + 1'b1;
								nxt_col = '0;
								if (!nl) begin
									mem_we    = 1'b1;
									wr_cursor = 1'b1;
									wr_row    = cur_row + 1'b1;
									wr_col    = '0;
									nxt_col   = CW'(1);
								end
							end else begin
								fin       = 1'b1;
								mem_we    = 1'b1;
								wr_cursor = 1'b1;
								cur_we    = 1'b1;
								nxt_col   = cur_col + 1'b1;
							end
						end
					endcase
				end
			end
			ST_COPY: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata;
				mem_raddr = ptr_q + COLS_A + 1'b1;
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = CH_SPACE;
				fin       = (ptr_q == last_q) && !fill_put_q;
			end
			ST_PUT: begin
				mem_we    = 1'b1;
				wr_cursor = 1'b1;
				cur_we    = 1'b1;
				nxt_col   = cur_col + 1'b1;
				fin       = 1'b1;
			end
			default: begin
			end
		endcase

		mem_waddr = wr_cursor ? cell_addr(AW'(tix), AW'(wr_row), AW'(wr_col)) : ptr_q;

		res_d = '0;
		if (term_ok_q) begin
			res_d.cursor_col = 7'(nxt_col);
			res_d.cursor_row = 5'(nxt_row);
			res_d.scrolled   = scrolled_q;
			if (state_q == ST_EXEC && op_q == OP_READ && rd_ok_q) begin
				res_d.cell_char = mem_rdata;
				res_d.cell_attr = attr;
			end
		end

		res_valid = out_free && (fin || state_q == ST_HOLD);
		res       = (state_q == ST_HOLD) ? res_q : res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			ptr_q      <= '0;
			scrolled_q <= 1'b0;
			for (int i = 0; i < TERMINALS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_COPY || state_q == ST_FILL) begin
				ptr_q <= ptr_q + 1'b1;
			end else if (state_q == ST_EXEC) begin
				ptr_q <= start_addr;
			end
			if (accept) begin
				scrolled_q <= 1'b0;
			end else if (scroll_go) begin
				scrolled_q <= 1'b1;
			end
			if (cur_we) begin
				col_q[tix] <= nxt_col;
				row_q[tix] <= nxt_row;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= op_t'(op);
			term_q    <= terminal;
			term_ok_q <= ({1'b0, terminal} < 3'(TERMINALS));
			char_q    <= char_code;
			rd_ok_q   <= ({3'b000, cell_row} < 8'(ROWS)) && ({2'b00, cell_col} < 9'(COLS));
		end
		if (state_q == ST_EXEC) begin
			last_q     <= end_addr;
			fill_put_q <= (op_q == OP_PUT) && !nl;
		end
		if (fin) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== hw/rtl/tcw_checker.sv =====
// Port-level checks for the text console writer, bound to the top level.
// Depends on text_console_writer_top_assert.svh.
`include "text_console_writer_top_assert.svh"

module tcw_checker #(
	parameter int ROWS = 25
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] cell_char,
	input logic [6:0] cursor_col,
	input logic [4:0] cursor_row,
	input logic       scrolled
);

	logic        at_bottom;
	logic [14:0] shown;

	assign at_bottom = (cursor_row == 5'(ROWS - 1)) && (cell_char == 8'd0);
	assign shown     = {cursor_col, cell_char};

	// a taken request always makes the sequencer busy in the following cycle
	`TCW_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request not held busy")

	// results only come out of active work, never straight from idle
	`TCW_ASSERT_IMP(a_result_from_work, $rose(out_valid), $past(in_stall), "result from idle")

	// a scroll leaves the cursor on the bottom row and is never a read
	`TCW_ASSERT_IMP(a_scroll_bottom, out_valid && scrolled, at_bottom, "scroll off bottom")

	`TCW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(shown), "result moved")

endmodule

bind text_console_writer_top tcw_checker #(
	.ROWS(ROWS)
) u_tcw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.cell_char(cell_char),
	.cursor_col(cursor_col),
	.cursor_row(cursor_row),
	.scrolled(scrolled)
);
